/* rtl/rsmc_pkg.sv */
// Shared types, widths and the multiply-accumulate program of the segment/mesh hit block.
// No dependencies; every other file in rtl/ imports this package.
package rsmc_pkg;

  localparam int COORD_W     = 24;
  localparam int VEC_W       = COORD_W + 1;
  localparam int OPD_W       = VEC_W + 1;
  localparam int PROD_W      = 2 * OPD_W;
  localparam int LO_W        = 25;
  localparam int CROSS_W     = 51;
  localparam int DOT_W       = 80;
  localparam int ACC_W       = 102;
  localparam int ROOT_W      = 50;
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int T_FRAC_BITS = 30;
  localparam int Q_W         = T_FRAC_BITS + 1;
  localparam int NORM_W      = 32;
  localparam int MAX_TRIANGLES = 1024;
  localparam int IDX_W       = $clog2(MAX_TRIANGLES);
  localparam int THR_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
    logic   last_triangle;
  } in_item_t;

  typedef struct packed {
    logic                     hit;
    logic [Q_W-1:0]           hit_t;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic [IDX_W-1:0]         hit_index;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X, CFG_START_Y, CFG_START_Z,
    CFG_END_X, CFG_END_Y, CFG_END_Z,
    CFG_CULL, CFG_THRESH
  } cfg_reg_t;

  typedef enum logic [1:0] {VEC_D, VEC_E1, VEC_E2, VEC_S} vec_id_t;
  typedef enum logic [2:0] {OPK_VEC, OPK_CLO, OPK_CHI, OPK_MLO, OPK_MHI} opk_t;
  typedef enum logic [1:0] {SH_0, SH_25, SH_50} shamt_t;
  typedef enum logic [2:0] {
    DST_NONE, DST_C0, DST_C1, DST_C2, DST_A, DST_U, DST_V, DST_T
  } dst_t;

  typedef struct packed {
    opk_t       kind;
    vec_id_t    vid;
    logic [1:0] comp;
  } opnd_t;

  typedef struct packed {
    opnd_t  a;
    opnd_t  b;
    logic   sub;
    logic   clr;
    shamt_t sh;
    dst_t   dst;
  } mc_op_t;

  // Program groups: crosses into C, dots into A/U/V/T, then the squared normal length.
  localparam logic [3:0] GRP_DXE2 = 4'd0;
  localparam logic [3:0] GRP_A    = 4'd1;
  localparam logic [3:0] GRP_U    = 4'd2;
  localparam logic [3:0] GRP_SXE1 = 4'd3;
  localparam logic [3:0] GRP_V    = 4'd4;
  localparam logic [3:0] GRP_T    = 4'd5;
  localparam logic [3:0] GRP_N    = 4'd6;
  localparam logic [3:0] GRP_SQ0  = 4'd7;
  localparam logic [3:0] GRP_SQ1  = 4'd8;
  localparam logic [3:0] GRP_SQ2  = 4'd9;

  typedef struct packed {
    logic       load;
    logic       op_valid;
    mc_op_t     op;
    logic       eval1;
    logic       eval2;
    logic       div_start;
    logic       div_norm;
    logic [1:0] k;
    logic       upd;
    logic       tri_done;
    logic       sqrt_start;
    logic       nq_wr;
    logic       out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic pass;
    logic last;
    logic div_done;
    logic sqrt_done;
    logic out_full;
  } dp_stat_t;

  function automatic logic [1:0] mod3_inc(input logic [1:0] k);
    unique case (k)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [2:0] grp_last(input logic [3:0] grp);
    return (grp >= GRP_SQ0) ? 3'd3 : 3'd5;
  endfunction

  function automatic dst_t cross_dst(input logic [1:0] k);
    unique case (k)
      2'd0:    return DST_C0;
      2'd1:    return DST_C1;
      default: return DST_C2;
    endcase
  endfunction

  function automatic mc_op_t mc_op(input logic [3:0] grp, input logic [2:0] sub);
    mc_op_t     op;
    logic [1:0] k;
    logic [1:0] k1;
    logic [1:0] k2;
    logic [1:0] j;
    logic       odd;
    logic       is_cross;
    logic       is_dot;
    vec_id_t    y;
    vec_id_t    z;
    dst_t       dd;
    logic [1:0] kq;
    op       = '0;
    k        = sub[2:1];
    k1       = mod3_inc(k);
    k2       = mod3_inc(k1);
    j        = sub[1:0];
    odd      = sub[0];
    is_cross = 1'b0;
    is_dot   = 1'b0;
    y        = VEC_D;
    z        = VEC_E2;
    dd       = DST_NONE;
    kq       = 2'd0;
    unique case (grp)
      GRP_DXE2: begin is_cross = 1'b1; y = VEC_D;  z = VEC_E2; end
      GRP_A:    begin is_dot = 1'b1;   y = VEC_E1; dd = DST_A; end
      GRP_U:    begin is_dot = 1'b1;   y = VEC_S;  dd = DST_U; end
      GRP_SXE1: begin is_cross = 1'b1; y = VEC_S;  z = VEC_E1; end
      GRP_V:    begin is_dot = 1'b1;   y = VEC_D;  dd = DST_V; end
      GRP_T:    begin is_dot = 1'b1;   y = VEC_E2; dd = DST_T; end
      GRP_N:    begin is_cross = 1'b1; y = VEC_E1; z = VEC_E2; end
      GRP_SQ0:  kq = 2'd0;
      GRP_SQ1:  kq = 2'd1;
      default:  kq = 2'd2;
    endcase
    if (is_cross) begin
      op.a   = '{kind: OPK_VEC, vid: y, comp: odd ? k2 : k1};
      op.b   = '{kind: OPK_VEC, vid: z, comp: odd ? k1 : k2};
      op.sub = odd;
      op.clr = !odd;
      op.sh  = SH_0;
      op.dst = odd ? cross_dst(k) : DST_NONE;
    end else if (is_dot) begin
      op.a   = '{kind: OPK_VEC, vid: y, comp: k};
      op.b   = '{kind: odd ? OPK_CHI : OPK_CLO, vid: VEC_D, comp: k};
      op.sub = 1'b0;
      op.clr = (sub == 3'd0);
      op.sh  = odd ? SH_25 : SH_0;
      op.dst = (sub == 3'd5) ? dd : DST_NONE;
    end else begin
      // mag^2 = lo*lo + 2*lo*hi*2^25 + hi*hi*2^50
      op.a   = '{kind: j[1] ? OPK_MHI : OPK_MLO, vid: VEC_D, comp: kq};
      op.b   = '{kind: j[0] ? OPK_MHI : OPK_MLO, vid: VEC_D, comp: kq};
      op.sub = 1'b0;
      op.clr = (j == 2'd0) && (kq == 2'd0);
      op.sh  = (j == 2'd0) ? SH_0 : ((j == 2'd3) ? SH_50 : SH_25);
      op.dst = DST_NONE;
    end
    return op;
  endfunction

endpackage

/* rtl/rsmc_div.sv */
// Restoring fraction divider: floor(num * 2^T_FRAC_BITS / den) for num <= den.
// Depends on rsmc_pkg.
module rsmc_div import rsmc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DOT_W-1:0] num,
  input  logic [DOT_W-1:0] den,
  output logic [Q_W-1:0]   quot,
  output logic             done
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DOT_W-1:0] rem_r;
  logic [DOT_W-1:0] den_r;
  logic [Q_W-1:0]   q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             first_r;
  logic             done_r;
  logic [DOT_W:0]   trial;
  logic [DOT_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        first_r <= 1'b1;
        cnt_r   <= CNT_W'(Q_W);
        rem_r   <= num;
        den_r   <= den;
        q_r     <= '0;
      end else if (busy_r) begin
        rem_r   <= ge ? diff[DOT_W-1:0] : trial[DOT_W-1:0];
        q_r     <= {q_r[Q_W-2:0], ge};
        first_r <= 1'b0;
        cnt_r   <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

/* rtl/rsmc_sqrt.sv */
// Bit-pair integer square root, one result bit per cycle.
// Depends on rsmc_pkg.
module rsmc_sqrt import rsmc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W-1:0]  remsh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  always_comb begin
    remsh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial = {1'b0, root_r, 2'b01};
    ge    = (remsh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W);
        rad_r  <= rad;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        rem_r  <= ge ? (remsh - trial) : remsh;
        root_r <= {root_r[ROOT_W-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

/* rtl/rsmc_dp.sv */
// Datapath: configuration, edge vectors, shared multiply-accumulate, hit tests,
// nearest-hit state and the result register. Depends on rsmc_pkg, rsmc_div, rsmc_sqrt.
module rsmc_dp import rsmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_item_t              in_data,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  coord_t                   start_r [3];
  coord_t                   end_r [3];
  logic                     cull_r;
  logic [THR_W-1:0]         thr_r;

  logic signed [VEC_W-1:0]  d_r [3];
  logic signed [VEC_W-1:0]  e1_r [3];
  logic signed [VEC_W-1:0]  e2_r [3];
  logic signed [VEC_W-1:0]  s_r [3];
  logic                     dz_r;
  logic                     last_r;

  logic signed [CROSS_W-1:0] c_r [3];
  logic signed [CROSS_W-1:0] bn_r [3];
  logic signed [DOT_W-1:0]  a_r, u_r, v_r, t_r;
  logic signed [DOT_W-1:0]  an_r, un_r, vn_r, tn_r;
  logic                     rej_r;
  logic                     pass_r;

  logic signed [PROD_W-1:0] prod_r;
  mc_op_t                   p_op_r;
  logic                     p_vld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  term;

  logic                     have_r;
  logic [Q_W-1:0]           best_t_r;
  logic [IDX_W-1:0]         best_idx_r;
  logic [IDX_W-1:0]         cnt_r;
  logic signed [NORM_W-1:0] nq_r [3];
  out_item_t                out_r;
  logic                     out_valid_r;

  coord_t                   vin [3][3];
  logic signed [OPD_W-1:0]  opa, opb;
  logic [DOT_W-1:0]         div_num, div_den;
  logic [Q_W-1:0]           div_q;
  logic                     div_done;
  logic [ROOT_W-1:0]        root;
  logic                     sqrt_done;
  logic [ROOT_W-1:0]        mag_k;
  logic [1:0]               kk;
  logic                     neg;
  logic signed [DOT_W:0]    uv_sum;
  logic signed [NORM_W-1:0] nq_val;
  logic [NORM_W-1:0]        nq_mag;

  function automatic logic [ROOT_W-1:0] mag_of(input logic signed [CROSS_W-1:0] n);
    logic [CROSS_W-1:0] m;
    m = n[CROSS_W-1] ? -n : n;
    return m[ROOT_W-1:0];
  endfunction

  function automatic logic signed [VEC_W-1:0] vsub(input coord_t x, input coord_t y);
    return $signed({x[COORD_W-1], x}) - $signed({y[COORD_W-1], y});
  endfunction

  function automatic logic signed [OPD_W-1:0] opnd_val(input opnd_t o);
    logic [1:0]                k;
    logic signed [VEC_W-1:0]   v;
    logic signed [CROSS_W-1:0] c;
    logic [ROOT_W-1:0]         m;
    k = (o.comp == 2'd3) ? 2'd0 : o.comp;
    unique case (o.vid)
      VEC_D:   v = d_r[k];
      VEC_E1:  v = e1_r[k];
      VEC_E2:  v = e2_r[k];
      default: v = s_r[k];
    endcase
    c = c_r[k];
    m = mag_of(bn_r[k]);
    unique case (o.kind)
      OPK_VEC: return {v[VEC_W-1], v};
      OPK_CLO: return {1'b0, c[LO_W-1:0]};
      OPK_CHI: return c[CROSS_W-1:LO_W];
      OPK_MLO: return {1'b0, m[LO_W-1:0]};
      OPK_MHI: return {1'b0, m[ROOT_W-1:LO_W]};
      default: return '0;
    endcase
  endfunction

  assign vin[0] = '{in_data.v0_x, in_data.v0_y, in_data.v0_z};
  assign vin[1] = '{in_data.v1_x, in_data.v1_y, in_data.v1_z};
  assign vin[2] = '{in_data.v2_x, in_data.v2_y, in_data.v2_z};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        start_r[i] <= '0;
        end_r[i]   <= '0;
      end
      cull_r <= 1'b0;
      thr_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_START_X: start_r[0] <= cfg_wdata[COORD_W-1:0];
        CFG_START_Y: start_r[1] <= cfg_wdata[COORD_W-1:0];
        CFG_START_Z: start_r[2] <= cfg_wdata[COORD_W-1:0];
        CFG_END_X:   end_r[0]   <= cfg_wdata[COORD_W-1:0];
        CFG_END_Y:   end_r[1]   <= cfg_wdata[COORD_W-1:0];
        CFG_END_Z:   end_r[2]   <= cfg_wdata[COORD_W-1:0];
        CFG_CULL:    cull_r     <= cfg_wdata[0];
        CFG_THRESH:  thr_r      <= cfg_wdata[THR_W-1:0];
      endcase
    end
  end

  // Multiplier operands and accumulator.
  always_comb begin
    opa      = opnd_val(cmd.op.a);
    opb      = opnd_val(cmd.op.b);
    prod_ext = ACC_W'(prod_r);
    unique case (p_op_r.sh)
      SH_25:   term = prod_ext <<< 25;
      SH_50:   term = prod_ext <<< 50;
      default: term = prod_ext;
    endcase
    acc_nxt = (p_op_r.clr ? '0 : acc_r) + (p_op_r.sub ? -term : term);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= cmd.op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]  <= vsub(end_r[i], start_r[i]);
        e1_r[i] <= vsub(vin[1][i], vin[0][i]);
        e2_r[i] <= vsub(vin[2][i], vin[0][i]);
        s_r[i]  <= vsub(start_r[i], vin[0][i]);
      end
      dz_r   <= (end_r[0] == start_r[0]) && (end_r[1] == start_r[1]) &&
                (end_r[2] == start_r[2]);
      last_r <= in_data.last_triangle;
    end
    if (cmd.op_valid) begin
      prod_r <= opa * opb;
      p_op_r <= cmd.op;
    end
    if (p_vld_r) begin
      acc_r <= acc_nxt;
      unique case (p_op_r.dst)
        DST_C0:  c_r[0] <= acc_nxt[CROSS_W-1:0];
        DST_C1:  c_r[1] <= acc_nxt[CROSS_W-1:0];
        DST_C2:  c_r[2] <= acc_nxt[CROSS_W-1:0];
        DST_A:   a_r    <= acc_nxt[DOT_W-1:0];
        DST_U:   u_r    <= acc_nxt[DOT_W-1:0];
        DST_V:   v_r    <= acc_nxt[DOT_W-1:0];
        DST_T:   t_r    <= acc_nxt[DOT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sign fold of the determinant, then the range tests.
  always_comb begin
    neg    = a_r[DOT_W-1];
    uv_sum = (DOT_W+1)'(un_r) + (DOT_W+1)'(vn_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.eval1) begin
      an_r  <= neg ? -a_r : a_r;
      un_r  <= neg ? -u_r : u_r;
      vn_r  <= neg ? -v_r : v_r;
      tn_r  <= neg ? -t_r : t_r;
      rej_r <= dz_r || (cull_r && (a_r <= 0));
    end
    if (cmd.eval2) begin
      pass_r <= !rej_r && ($unsigned(an_r) > DOT_W'(thr_r)) &&
                !un_r[DOT_W-1] && (un_r <= an_r) &&
                !vn_r[DOT_W-1] && (uv_sum <= (DOT_W+1)'(an_r)) &&
                !tn_r[DOT_W-1] && (tn_r <= an_r);
    end
  end

  // Shared divider for t and for the three normal components.
  always_comb begin
    kk      = (cmd.k == 2'd3) ? 2'd0 : cmd.k;
    mag_k   = mag_of(bn_r[kk]);
    div_num = cmd.div_norm ? DOT_W'(mag_k) : $unsigned(tn_r);
    div_den = cmd.div_norm ? DOT_W'(root) : $unsigned(an_r);
    nq_mag  = (have_r && (root != '0)) ? NORM_W'(div_q) : '0;
    nq_val  = bn_r[kk][CROSS_W-1] ? -$signed(nq_mag) : $signed(nq_mag);
  end

  rsmc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_q),
    .done  (div_done)
  );

  rsmc_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .rad   (acc_r[RAD_W-1:0]),
    .root  (root),
    .done  (sqrt_done)
  );

  // Nearest-hit state and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.upd && (!have_r || (div_q < best_t_r))) begin
        have_r     <= 1'b1;
        best_t_r   <= div_q;
        best_idx_r <= cnt_r;
        for (int i = 0; i < 3; i++) bn_r[i] <= c_r[i];
      end
      if (cmd.tri_done) cnt_r <= cnt_r + 1'b1;
      if (cmd.nq_wr) nq_r[kk] <= nq_val;
      if (cmd.out_load) begin
        out_r.hit       <= have_r;
        out_r.hit_t     <= have_r ? best_t_r : '0;
        out_r.hit_index <= have_r ? best_idx_r : '0;
        out_r.normal_x  <= nq_r[0];
        out_r.normal_y  <= nq_r[1];
        out_r.normal_z  <= nq_r[2];
        out_valid_r     <= 1'b1;
        have_r          <= 1'b0;
        cnt_r           <= '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.pass      = pass_r;
  assign stat.last      = last_r;
  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.out_full  = out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

endmodule

/* rtl/rsmc_ctrl.sv */
// Sequencer: steps the multiply-accumulate program, the tests, the divider,
// the square root and the result hand-off. Depends on rsmc_pkg.
module rsmc_ctrl import rsmc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RUN, ST_DRAIN, ST_EVAL1, ST_EVAL2, ST_CHK, ST_TDIV, ST_UPD,
    ST_FIN, ST_NDRAIN, ST_SQST, ST_SQWT, ST_NDST, ST_NDWT, ST_OUT
  } state_t;

  state_t     state_r;
  logic [3:0] grp_r;
  logic [2:0] sub_r;
  logic [1:0] k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      grp_r   <= '0;
      sub_r   <= '0;
      k_r     <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: if (in_valid) begin
          state_r <= ST_RUN;
          grp_r   <= GRP_DXE2;
          sub_r   <= '0;
        end
        ST_RUN: begin
          if (sub_r == grp_last(grp_r)) begin
            sub_r <= '0;
            if (grp_r == GRP_N) state_r <= ST_DRAIN;
            else if (grp_r == GRP_SQ2) state_r <= ST_NDRAIN;
            else grp_r <= grp_r + 1'b1;
          end else begin
            sub_r <= sub_r + 1'b1;
          end
        end
        ST_DRAIN: state_r <= ST_EVAL1;
        ST_EVAL1: state_r <= ST_EVAL2;
        ST_EVAL2: state_r <= ST_CHK;
        ST_CHK:   state_r <= stat.pass ? ST_TDIV : ST_FIN;
        ST_TDIV:  if (stat.div_done) state_r <= ST_UPD;
        ST_UPD:   state_r <= ST_FIN;
        ST_FIN: begin
          if (stat.last) begin
            state_r <= ST_RUN;
            grp_r   <= GRP_SQ0;
            sub_r   <= '0;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_NDRAIN: state_r <= ST_SQST;
        ST_SQST:   state_r <= ST_SQWT;
        ST_SQWT: if (stat.sqrt_done) begin
          state_r <= ST_NDST;
          k_r     <= '0;
        end
        ST_NDST: state_r <= ST_NDWT;
        ST_NDWT: if (stat.div_done) begin
          if (k_r == 2'd2) begin
            state_r <= ST_OUT;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= ST_NDST;
          end
        end
        ST_OUT: if (!stat.out_full) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.op     = mc_op(grp_r, sub_r);
    cmd.k      = k_r;
    in_ready   = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE:  cmd.load      = in_valid;
      ST_RUN:   cmd.op_valid  = 1'b1;
      ST_EVAL1: cmd.eval1     = 1'b1;
      ST_EVAL2: cmd.eval2     = 1'b1;
      ST_CHK:   cmd.div_start = stat.pass;
      ST_UPD:   cmd.upd       = 1'b1;
      ST_FIN:   cmd.tri_done  = 1'b1;
      ST_SQST:  cmd.sqrt_start = 1'b1;
      ST_NDST: begin
        cmd.div_start = 1'b1;
        cmd.div_norm  = 1'b1;
      end
      ST_NDWT: begin
        cmd.div_norm = 1'b1;
        cmd.nq_wr    = stat.div_done;
      end
      ST_OUT:   cmd.out_load  = !stat.out_full;
      default:  ;
    endcase
  end

endmodule

/* rtl/ray_segment_mesh_closest_hit.sv */
// Top level of the segment versus triangle-mesh nearest-hit block.
// Depends on rsmc_pkg, rsmc_ctrl and rsmc_dp (which holds rsmc_div and rsmc_sqrt).
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+-------------------------------------
//   input    | in_valid, in_ready, in_data    | one triangle (3 vertices, last flag)
//   result   | out_valid, out_ready, out_data | hit, t, unit normal, triangle index
//   config   | cfg_we, cfg_index, cfg_wdata   | segment ends, culling, parallel limit
//
// A triangle runs the accept step, the 42 steps of the single 26x26 multiply-accumulate
// program, then drain, two test steps, check and finish; a triangle that passes the range
// tests also runs the 31-step divider for t and the update before it finishes.
// The last triangle of a mesh then adds 12 multiply-accumulate steps for the squared
// normal length, a drain and a start step, the square root, three normal divisions
// and a step that loads the result register.
// Reset is synchronous and active low; it clears the configuration and the
// nearest-hit state. A finished result waits in the output register, and the next
// triangle transfer is taken meanwhile; only the following mesh end stalls on it.
module ray_segment_mesh_closest_hit import rsmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // The controller and the datapath talk only through these two bundles.
  ctl_cmd_t cmd;
  dp_stat_t stat;

  rsmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rsmc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* tb/tb_ray_segment_mesh_closest_hit.sv */
// Self-checking testbench for the segment versus triangle-mesh nearest-hit block.
// Depends on rsmc_pkg and the RTL top ray_segment_mesh_closest_hit; it needs nothing else.
// Random meshes under random flow control are checked against an exact integer predictor.
module tb_ray_segment_mesh_closest_hit;
  import rsmc_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef wide_t vec3_t [3];

  localparam int IDLE_LIMIT   = 20000;  // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES  = 3000;   // long receiver hold-off

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  ray_segment_mesh_closest_hit DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the configuration and of the nearest-hit state.
  logic [31:0]      seg_cfg [8];
  logic             near_valid;
  logic [63:0]      near_t;
  wide_t            near_normal [3];
  logic [IDX_W-1:0] near_index;
  logic [IDX_W-1:0] tri_count;

  in_item_t  tri_queue [$];     // triangles waiting to be offered
  out_item_t hit_reports [$];   // predicted results, oldest first
  int        mismatches = 0;
  int        hold_requests = 0;
  int        holds_done = 0;
  int        idle_cycles = 0;

  function automatic wide_t seg_coord(int i);
    return wide_t'($signed(seg_cfg[i][COORD_W-1:0]));
  endfunction

  // x . (y cross z), exact in 128 bits.
  function automatic wide_t triple(vec3_t x, vec3_t y, vec3_t z);
    return x[0] * (y[1] * z[2] - y[2] * z[1]) + x[1] * (y[2] * z[0] - y[0] * z[2])
         + x[2] * (y[0] * z[1] - y[1] * z[0]);
  endfunction

  // Runs one triangle through the Moller-Trumbore test and keeps the nearest hit.
  function automatic void test_triangle(in_item_t it);
    vec3_t d, e1, e2, s, v0, v1, v2;
    wide_t det, adet, u, v, t;
    logic [127:0] tq;
    logic neg;
    v0 = '{wide_t'(it.v0_x), wide_t'(it.v0_y), wide_t'(it.v0_z)};
    v1 = '{wide_t'(it.v1_x), wide_t'(it.v1_y), wide_t'(it.v1_z)};
    v2 = '{wide_t'(it.v2_x), wide_t'(it.v2_y), wide_t'(it.v2_z)};
    for (int k = 0; k < 3; k++) begin
      d[k]  = seg_coord(3 + k) - seg_coord(k);
      e1[k] = v1[k] - v0[k];
      e2[k] = v2[k] - v0[k];
      s[k]  = seg_coord(k) - v0[k];
    end
    if (d[0] == 0 && d[1] == 0 && d[2] == 0) return;
    det = triple(e1, d, e2);
    // A back face has a non-positive determinant.
    if (seg_cfg[CFG_CULL][0] && det <= 0) return;
    neg  = det < 0;
    adet = neg ? -det : det;
    if (adet <= wide_t'({1'b0, seg_cfg[CFG_THRESH]})) return;
    u = triple(s, d, e2);
    v = triple(d, s, e1);
    t = triple(e2, s, e1);
    if (neg) begin
      u = -u;
      v = -v;
      t = -t;
    end
    if (u < 0 || u > adet) return;
    if (v < 0 || u + v > adet) return;
    if (t < 0 || t > adet) return;
    tq = ($unsigned(t) << T_FRAC_BITS) / $unsigned(adet);
    // On equal quantized t the earlier triangle stays.
    if (near_valid && tq[63:0] >= near_t) return;
    near_valid     = 1'b1;
    near_t         = tq[63:0];
    near_index     = tri_count;
    near_normal[0] = e1[1] * e2[2] - e1[2] * e2[1];
    near_normal[1] = e1[2] * e2[0] - e1[0] * e2[2];
    near_normal[2] = e1[0] * e2[1] - e1[1] * e2[0];
  endfunction

  // Accepts one triangle; the mesh end queues the result and clears the state.
  function automatic void take_triangle(in_item_t it);
    out_item_t    rep;
    logic [127:0] mag [3];
    logic [127:0] sq, root, c, q;
    test_triangle(it);
    tri_count = tri_count + 1'b1;
    if (!it.last_triangle) return;
    rep = '0;
    sq  = '0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = near_normal[k] < 0 ? -near_normal[k] : near_normal[k];
      sq     = sq + mag[k] * mag[k];
    end
    root = '0;
    for (int b = 62; b >= 0; b--) begin
      c = root | (128'd1 << b);
      if (c * c <= sq) root = c;
    end
    rep.hit       = near_valid;
    rep.hit_t     = near_valid ? near_t[Q_W-1:0] : '0;
    rep.hit_index = near_valid ? near_index : '0;
    for (int k = 0; k < 3; k++) begin
      q = (near_valid && root != 0) ? (mag[k] << 30) / root : '0;
      if (near_normal[k] < 0) q = -q;
      case (k)
        0: rep.normal_x = q[NORM_W-1:0];
        1: rep.normal_y = q[NORM_W-1:0];
        default: rep.normal_z = q[NORM_W-1:0];
      endcase
    end
    hit_reports.insert(hit_reports.size(), rep);
    near_valid = 1'b0;
    near_t     = '0;
    near_index = '0;
    tri_count  = '0;
    for (int k = 0; k < 3; k++) near_normal[k] = '0;
  endfunction

  // Sender: bursts of random length separated by random gaps; some bursts are long.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        take_triangle(in_data);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (tri_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= tri_queue.pop_front();
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 120);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a stall pattern whose density is redrawn at random from time to time, plus a
  // long hold-off whenever the stimulus asks for one.
  int ready_pct = 100;
  int pat_count = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (pat_count == 0) begin
      pat_count <= 300;
      case ($urandom_range(0, 3))
        0: ready_pct <= 100;
        1: ready_pct <= 70;
        2: ready_pct <= 25;
        default: ready_pct <= 5;
      endcase
    end else begin
      pat_count <= pat_count - 1;
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (holds_done < hold_requests) begin
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // Result checker: every result transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (hit_reports.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result transfer: %p", out_data);
      end else begin
        want = hit_reports.pop_front();
        if (out_data.hit !== want.hit || out_data.hit_t !== want.hit_t
            || out_data.normal_x !== want.normal_x || out_data.normal_y !== want.normal_y
            || out_data.normal_z !== want.normal_z || out_data.hit_index !== want.hit_index)
        begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("result mismatch: hit %0d/%0d t %h/%h idx %0d/%0d (expected/actual)",
                     want.hit, out_data.hit, want.hit_t, out_data.hit_t,
                     want.hit_index, out_data.hit_index);
            $display("  normal expected %h %h %h actual %h %h %h",
                     want.normal_x, want.normal_y, want.normal_z,
                     out_data.normal_x, out_data.normal_y, out_data.normal_z);
          end
        end
      end
    end
  end

  // Watchdog on transfers of any kind.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_ray_segment_mesh_closest_hit: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic coord_t clamp24(longint x);
    if (x > 8388607) return coord_t'(8388607);
    if (x < -8388608) return coord_t'(-8388608);
    return coord_t'(x);
  endfunction

  function automatic int rand_pos(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Triangle whose centroid sits on the segment at t = tq/256.
  task automatic add_crossing(int tq, int spread, logic last);
    in_item_t it;
    longint p [3];
    longint a [3];
    longint b [3];
    for (int k = 0; k < 3; k++) begin
      p[k] = longint'(seg_coord(k))
           + ((longint'(seg_coord(3 + k)) - longint'(seg_coord(k))) * tq) / 256;
      a[k] = rand_pos(spread);
      b[k] = rand_pos(spread);
    end
    it.v0_x = clamp24(p[0] + a[0]);  it.v0_y = clamp24(p[1] + a[1]);
    it.v0_z = clamp24(p[2] + a[2]);
    it.v1_x = clamp24(p[0] + b[0]);  it.v1_y = clamp24(p[1] + b[1]);
    it.v1_z = clamp24(p[2] + b[2]);
    it.v2_x = clamp24(p[0] - a[0] - b[0]);  it.v2_y = clamp24(p[1] - a[1] - b[1]);
    it.v2_z = clamp24(p[2] - a[2] - b[2]);
    it.last_triangle = last;
    tri_queue.insert(tri_queue.size(), it);
  endtask

  task automatic add_noise(logic last);
    in_item_t     it;
    logic [255:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom()};
    it = raw[$bits(in_item_t)-1:0];
    it.last_triangle = last;
    tri_queue.insert(tri_queue.size(), it);
  endtask

  task automatic add_flat(coord_t c, logic last);
    in_item_t it;
    it = '{c, c, c, c, c, c, c, c, c, last};
    tri_queue.insert(tri_queue.size(), it);
  endtask

  // Random mesh: mostly crossing triangles, with noise and collapsed ones mixed in.
  task automatic add_mesh(int len);
    int pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) add_crossing($urandom_range(0, 256), 1 << $urandom_range(4, 18),
                                 i == len - 1);
      else if (pick < 9) add_noise(i == len - 1);
      else add_flat(coord_t'($urandom()), i == len - 1);
    end
  endtask

  task automatic write_reg(cfg_reg_t r, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= val;
    seg_cfg[r] = (r == CFG_CULL) ? {31'b0, val[0]} :
                 (r == CFG_THRESH) ? val : {8'b0, val[COORD_W-1:0]};
  endtask

  task automatic set_segment(int sx, int sy, int sz, int ex, int ey, int ez,
                             logic cull, logic [31:0] thr);
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_START_Z, sz);
    write_reg(CFG_END_X, ex);
    write_reg(CFG_END_Y, ey);
    write_reg(CFG_END_Z, ez);
    write_reg(CFG_CULL, {31'b0, cull});
    write_reg(CFG_THRESH, thr);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until the sender is empty and every prediction has been matched.
  task automatic drain();
    do @(posedge clk);
    while (tri_queue.size() > 0 || in_valid || hit_reports.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_segment(logic [31:0] thr);
    set_segment(rand_pos(1 << 20), rand_pos(1 << 20), rand_pos(1 << 20),
                rand_pos(1 << 20), rand_pos(1 << 20), rand_pos(1 << 20),
                1'($urandom_range(0, 1)), thr);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) seg_cfg[i] = '0;
    near_valid = 1'b0;
    near_t     = '0;
    near_index = '0;
    tri_count  = '0;
    for (int k = 0; k < 3; k++) near_normal[k] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Registers still at reset: a zero-length segment that can never hit.
    add_flat(coord_t'(8388607), 1'b0);
    add_flat(coord_t'(-8388608), 1'b1);
    add_noise(1'b0);
    add_crossing(128, 1000, 1'b1);
    drain();

    // Segment spanning the full coordinate range, no culling, no parallel limit.
    set_segment(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607, 1'b0, 32'd0);
    add_crossing(0, 1 << 12, 1'b1);      // hit right at the start point
    add_crossing(256, 1 << 12, 1'b1);    // hit right at the end point
    add_crossing(200, 1 << 14, 1'b0);
    add_crossing(60, 1 << 14, 1'b0);
    // Equal t: the first one stays.
    tri_queue.insert(tri_queue.size(), tri_queue[tri_queue.size() - 1]);
    add_flat(coord_t'(0), 1'b0);         // collapsed triangle, zero determinant
    add_noise(1'b1);
    drain();

    // Culling on, parallel limit at its maximum.
    set_segment(8388607, 0, -8388608, -8388608, 1 << 12, 8388607, 1'b1, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) add_crossing($urandom_range(0, 256), 1 << 16, i == 5);
    drain();

    // Nonzero start equal to the end: still a zero-length segment.
    set_segment(12345, -6789, 4242, 12345, -6789, 4242, 1'b0, 32'd0);
    add_crossing(100, 1 << 10, 1'b1);
    drain();

    // Long mesh: the triangle index wraps; late triangles get nearer and nearer.
    random_segment(32'd0);
    for (int i = 0; i < 1100; i++) begin
      if (i % 40 == 39) add_crossing(250 - i / 5, 1 << 15, i == 1099);
      else add_noise(i == 1099);
    end
    drain();

    // Receiver holds off while one-triangle meshes keep coming, so the input stalls.
    random_segment(32'd0);
    hold_requests = hold_requests + 1;
    for (int i = 0; i < 40; i++) add_mesh(1);
    drain();

    // Random phases with random segments and random mesh lengths.
    for (int ph = 0; ph < 16; ph++) begin
      random_segment(($urandom_range(0, 3) == 0) ? $urandom() : 32'd0);
      for (int m = 0; m < 10; m++) add_mesh($urandom_range(1, 8));
      drain();
    end

    if (hit_reports.size() != 0) mismatches = mismatches + 1;
    if (mismatches == 0) begin
      $display("tb_ray_segment_mesh_closest_hit: PASS");
    end else begin
      $display("tb_ray_segment_mesh_closest_hit: FAIL");
    end
    $finish;
  end

endmodule
